// ----- rtl/m3inv_pkg.sv -----
// shared constants for the 3x3 matrix inverse pipeline
package m3inv_pkg;

    localparam int COEF_WIDTH_DEF   = 16;
    localparam int RESULT_WIDTH_DEF = 32;
    localparam int COEF_MAX_USED    = 16;
    localparam int FRAC_IN          = 12;
    localparam int FRAC_OUT         = 16;
    localparam int QUOT_SHIFT       = FRAC_IN + FRAC_OUT + 1;
    localparam int DIV_W            = 64;
    localparam int N_ELEM           = 9;

endpackage

// ----- rtl/matrix3x3_inverse_unit.sv -----
// 3x3 matrix inverse by cofactors, fully pipelined with one restoring divider lane per element
//
// s_axis carries one 3x3 matrix per word: nine signed Q3.12 coefficients
// m00..m22, row by row, m00 in the lowest bits of tdata.
// m_axis carries the inverse per word: nine signed Q15.16 results inv00..inv22,
// saturated at the RESULT_WIDTH limits, inv00 in the lowest bits of tdata,
// and tuser = singular, set when the determinant is zero (results then zero).
// the nine divider lanes each hold RESULT_WIDTH + 1 quotient bit stages.
// throughput: one matrix per cycle, a new word may enter every cycle while the output is not stalled.
// an input register, then products, cofactors, determinant and division setup
// in five stages, then one quotient bit per stage, then a rounding and
// saturation stage. reset clears all valid bits; data registers are not reset.
// when the receiver holds tready low with a word waiting, the whole pipeline
// holds, bubbles included, and s_axis_tready drops in the same cycle; while
// the output stage is empty s_axis_tready stays high.
module matrix3x3_inverse_unit #(
    parameter int COEF_WIDTH   = m3inv_pkg::COEF_WIDTH_DEF,
    parameter int RESULT_WIDTH = m3inv_pkg::RESULT_WIDTH_DEF
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      s_axis_tvalid,
    output logic                                      s_axis_tready,
    // m00, m01, m02, m10, m11, m12, m20, m21, m22
    input  logic [((9*COEF_WIDTH+7)/8)*8-1:0]         s_axis_tdata,
    output logic                                      m_axis_tvalid,
    input  logic                                      m_axis_tready,
    // inv00, inv01, inv02, inv10, inv11, inv12, inv20, inv21, inv22
    output logic [((9*RESULT_WIDTH+7)/8)*8-1:0]       m_axis_tdata,
    // singular
    output logic                                      m_axis_tuser
);
    import m3inv_pkg::*;

    localparam int EW    = (COEF_WIDTH > COEF_MAX_USED) ? COEF_MAX_USED : COEF_WIDTH;
    localparam int PW    = 2 * EW;
    localparam int NW    = PW + 1;
    localparam int DPW   = EW + NW;
    localparam int DW    = DPW + 2;
    localparam int RW    = RESULT_WIDTH;
    localparam int DSTG  = RW + 1;
    localparam int LAT   = RW + 8;
    localparam int OUT_W = ((9*RESULT_WIDTH+7)/8)*8;

    logic [LAT-1:0] vld_reg;
    logic [LAT-1:0] vld_next;
    logic           en;

    logic signed [EW-1:0]  coef_reg [N_ELEM];
    logic signed [PW-1:0]  prod_reg [2*N_ELEM];
    logic signed [EW-1:0]  abc1_reg [3];
    logic signed [NW-1:0]  num2_reg [N_ELEM];
    logic signed [EW-1:0]  abc2_reg [3];
    logic signed [DPW-1:0] dprod_reg [3];
    logic signed [NW-1:0]  num3_reg [N_ELEM];
    logic signed [DW-1:0]  den_reg;
    logic signed [NW-1:0]  num4_reg [N_ELEM];

    logic [DIV_W-1:0] rem_reg  [DSTG+1][N_ELEM];
    logic [DIV_W-1:0] rem_next [DSTG+1][N_ELEM];
    logic [DIV_W-1:0] ud_reg   [DSTG+1];
    logic [DSTG-1:0]  q_reg    [DSTG+1][N_ELEM];
    logic [DSTG-1:0]  q_next   [DSTG+1][N_ELEM];
    logic             neg_reg  [DSTG+1][N_ELEM];
    logic             ovf_reg  [DSTG+1][N_ELEM];
    logic             ovf_next [N_ELEM];
    logic             zero_reg [DSTG+1];

    logic [DIV_W-1:0] ud_next;
    logic [RW-1:0]    res_next [N_ELEM];
    logic [OUT_W-1:0] tdata_reg;
    logic [OUT_W-1:0] tdata_next;
    logic             sing_reg;

    assign en            = ~vld_reg[LAT-1] | m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = vld_reg[LAT-1];
    assign m_axis_tdata  = tdata_reg;
    assign m_axis_tuser  = sing_reg;

    assign vld_next = {vld_reg[LAT-2:0], s_axis_tvalid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    // front stages: input register, products, cofactors, determinant
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < N_ELEM; i++)
            begin
                coef_reg[i] <= s_axis_tdata[i*COEF_WIDTH +: EW];
            end
            // a b c / d e f / g h k at indexes 0..8
            prod_reg[0]  <= coef_reg[5] * coef_reg[7];
            prod_reg[1]  <= coef_reg[4] * coef_reg[8];
            prod_reg[2]  <= coef_reg[1] * coef_reg[8];
            prod_reg[3]  <= coef_reg[2] * coef_reg[7];
            prod_reg[4]  <= coef_reg[2] * coef_reg[4];
            prod_reg[5]  <= coef_reg[1] * coef_reg[5];
            prod_reg[6]  <= coef_reg[3] * coef_reg[8];
            prod_reg[7]  <= coef_reg[5] * coef_reg[6];
            prod_reg[8]  <= coef_reg[2] * coef_reg[6];
            prod_reg[9]  <= coef_reg[0] * coef_reg[8];
            prod_reg[10] <= coef_reg[0] * coef_reg[5];
            prod_reg[11] <= coef_reg[2] * coef_reg[3];
            prod_reg[12] <= coef_reg[4] * coef_reg[6];
            prod_reg[13] <= coef_reg[3] * coef_reg[7];
            prod_reg[14] <= coef_reg[0] * coef_reg[7];
            prod_reg[15] <= coef_reg[1] * coef_reg[6];
            prod_reg[16] <= coef_reg[1] * coef_reg[3];
            prod_reg[17] <= coef_reg[0] * coef_reg[4];
            for (int i = 0; i < 3; i++)
            begin
                abc1_reg[i] <= coef_reg[i];
                abc2_reg[i] <= abc1_reg[i];
            end
            for (int i = 0; i < N_ELEM; i++)
            begin
                num2_reg[i] <= NW'(prod_reg[2*i]) - NW'(prod_reg[2*i+1]);
                num3_reg[i] <= num2_reg[i];
                num4_reg[i] <= num3_reg[i];
            end
            // negated determinant by expansion along the first row
            dprod_reg[0] <= abc2_reg[0] * num2_reg[0];
            dprod_reg[1] <= abc2_reg[1] * num2_reg[3];
            dprod_reg[2] <= abc2_reg[2] * num2_reg[6];
            den_reg      <= DW'(dprod_reg[0]) + DW'(dprod_reg[1]) + DW'(dprod_reg[2]);
        end
    end

    // division setup and one quotient bit per stage
    always_comb
    begin
        ud_next = den_reg[DW-1] ? DIV_W'(-den_reg) : DIV_W'(den_reg);
        for (int l = 0; l < N_ELEM; l++)
        begin
            rem_next[0][l] = (num4_reg[l][NW-1] ? DIV_W'(-num4_reg[l]) : DIV_W'(num4_reg[l]))
                             << QUOT_SHIFT;
            q_next[0][l]   = '0;
            ovf_next[l]    = (rem_next[0][l] >> DSTG) >= ud_next;
        end
        for (int k = 0; k < DSTG; k++)
        begin
            for (int l = 0; l < N_ELEM; l++)
            begin
                if ((rem_reg[k][l] >> (RW - k)) >= ud_reg[k])
                begin
                    rem_next[k+1][l] = rem_reg[k][l] - (ud_reg[k] << (RW - k));
                    q_next[k+1][l]   = {q_reg[k][l][DSTG-2:0], 1'b1};
                end
                else
                begin
                    rem_next[k+1][l] = rem_reg[k][l];
                    q_next[k+1][l]   = {q_reg[k][l][DSTG-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ud_reg[0]   <= ud_next;
            zero_reg[0] <= (den_reg == '0);
            for (int l = 0; l < N_ELEM; l++)
            begin
                rem_reg[0][l] <= rem_next[0][l];
                q_reg[0][l]   <= q_next[0][l];
                neg_reg[0][l] <= num4_reg[l][NW-1] ^ den_reg[DW-1];
                ovf_reg[0][l] <= ovf_next[l];
            end
            for (int k = 0; k < DSTG; k++)
            begin
                ud_reg[k+1]   <= ud_reg[k];
                zero_reg[k+1] <= zero_reg[k];
                for (int l = 0; l < N_ELEM; l++)
                begin
                    rem_reg[k+1][l] <= rem_next[k+1][l];
                    q_reg[k+1][l]   <= q_next[k+1][l];
                    neg_reg[k+1][l] <= neg_reg[k][l];
                    ovf_reg[k+1][l] <= ovf_reg[k][l];
                end
            end
        end
    end

    // round half away from zero, apply sign, saturate
    always_comb
    begin
        logic [DSTG:0]   qp1;
        logic [DSTG-1:0] qr;
        logic [DSTG-1:0] half;
        half       = DSTG'(1) << (RW - 1);
        tdata_next = '0;
        for (int l = 0; l < N_ELEM; l++)
        begin
            qp1 = {1'b0, q_reg[DSTG][l]} + (DSTG+1)'(1);
            qr  = qp1[DSTG:1];
            if (zero_reg[DSTG])
            begin
                res_next[l] = '0;
            end
            else if (neg_reg[DSTG][l])
            begin
                if (ovf_reg[DSTG][l] || (qr > half))
                begin
                    res_next[l] = {1'b1, {(RW-1){1'b0}}};
                end
                else
                begin
                    res_next[l] = -qr[RW-1:0];
                end
            end
            else
            begin
                if (ovf_reg[DSTG][l] || (qr >= half))
                begin
                    res_next[l] = {1'b0, {(RW-1){1'b1}}};
                end
                else
                begin
                    res_next[l] = qr[RW-1:0];
                end
            end
            tdata_next[l*RW +: RW] = res_next[l];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tdata_reg <= tdata_next;
            sing_reg  <= zero_reg[DSTG];
        end
    end

    a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
        else $error("singular word with nonzero results");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled output word changed");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !vld_reg[LAT-1] |-> s_axis_tready)
        else $error("input stalled with empty output stage");

endmodule
